// ===== src/binary_trie_min_xor_macros.svh =====
// Assertion macros used by the trie RTL.
`ifndef BINARY_TRIE_MIN_XOR_MACROS_SVH
`define BINARY_TRIE_MIN_XOR_MACROS_SVH
`ifndef ASSERT_OFF
`define BTMX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("btmx: implication check failed");
`define BTMX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("btmx: next-cycle check failed");
`else
`define BTMX_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BTMX_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/btmx_pkg.sv =====
package btmx_pkg;

	localparam int NODE_COUNT = 4096;
	localparam int KEY_BITS   = 32;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int FREE_W     = $clog2(NODE_COUNT + 1);
	localparam int ROW_W      = 2 * NODE_W;
	localparam int KW_W       = 6;
	localparam int IDX_W      = $clog2(KEY_BITS);

	localparam logic [FREE_W-1:0] FIRST_FREE = FREE_W'(3);
	localparam logic [NODE_W-1:0] ROOT0      = NODE_W'(1);
	localparam logic [NODE_W-1:0] ROOT1      = NODE_W'(2);
	localparam logic [KW_W-1:0]   KW_RESET   = KW_W'(32);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	// one node: link followed on a one bit, link followed on a zero bit
	typedef struct packed {
		logic [NODE_W-1:0] l1;
		logic [NODE_W-1:0] l0;
	} row_t;

	typedef struct packed {
		logic              wr_en;
		logic [NODE_W-1:0] wr_addr;
		row_t              wr_data;
		logic              rd_en;
		logic [NODE_W-1:0] rd_addr;
	} mem_req_t;

endpackage

// ===== src/btmx_node_ram.sv =====
module btmx_node_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/btmx_ctrl.sv =====
`include "binary_trie_min_xor_macros.svh"

module btmx_ctrl
	import btmx_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                operation,
	input  logic [KEY_BITS-1:0] key,
	input  logic                tree_select,
	input  logic [KW_W-1:0]     key_width,
	output logic                done,
	output logic [KEY_BITS-1:0] min_xor,
	output logic [1:0]          status,
	output mem_req_t            mem_req,
	input  row_t                rd_row
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_ALLOC
	} state_t;

	state_t              state_q;
	logic [NODE_W-1:0]   clr_q;
	logic                op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [NODE_W-1:0]   node_q;
	logic [KW_W-1:0]     lvl_q;
	logic                first_q;
	logic [KEY_BITS-1:0] res_q;
	row_t                row_q;
	logic [FREE_W-1:0]   free_q;
	logic                done_q;
	logic [KEY_BITS-1:0] min_xor_q;
	logic [1:0]          status_q;

	logic [KW_W-1:0]   kw_eff;
	logic [KW_W-1:0]   lvl_m1;
	logic [IDX_W-1:0]  bit_idx;
	logic              kbit;
	logic [NODE_W-1:0] match;
	logic [NODE_W-1:0] other;
	logic [FREE_W-1:0] avail;
	logic              full;
	row_t              alloc_row;

	assign kw_eff  = (key_width > KW_W'(KEY_BITS)) ? KW_W'(KEY_BITS) : key_width;
	assign lvl_m1  = lvl_q - KW_W'(1);
	assign bit_idx = lvl_m1[IDX_W-1:0];
	assign kbit    = key_q[bit_idx];
	assign match   = kbit ? rd_row.l1 : rd_row.l0;
	assign other   = kbit ? rd_row.l0 : rd_row.l1;
	assign avail   = FREE_W'(NODE_COUNT) - free_q;
	assign full    = FREE_W'(lvl_q) > avail;

	always_comb begin
		alloc_row = row_q;
		if (kbit) begin
			alloc_row.l1 = free_q[NODE_W-1:0];
		end else begin
			alloc_row.l0 = free_q[NODE_W-1:0];
		end
	end

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = clr_q;
			end
			S_IDLE: begin
				mem_req.rd_en   = start;
				mem_req.rd_addr = tree_select ? ROOT1 : ROOT0;
			end
			S_WALK: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = (op_q == OP_QUERY && match == '0) ? other : match;
			end
			S_ALLOC: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = node_q;
				mem_req.wr_data = alloc_row;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			free_q    <= FIRST_FREE;
			done_q    <= 1'b0;
			op_q      <= OP_INSERT;
			key_q     <= '0;
			node_q    <= '0;
			lvl_q     <= '0;
			first_q   <= 1'b0;
			res_q     <= '0;
			row_q     <= '0;
			min_xor_q <= '0;
			status_q  <= STATUS_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (clr_q == {NODE_W{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q    <= operation;
						key_q   <= key;
						node_q  <= tree_select ? ROOT1 : ROOT0;
						lvl_q   <= kw_eff;
						first_q <= 1'b1;
						res_q   <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					first_q <= 1'b0;
					if (op_q == OP_INSERT) begin
						if (lvl_q == '0) begin
							done_q    <= 1'b1;
							min_xor_q <= '0;
							status_q  <= STATUS_OK;
							state_q   <= S_IDLE;
						end else if (match != '0) begin
							node_q <= match;
							lvl_q  <= lvl_m1;
						end else if (full) begin
							done_q    <= 1'b1;
							min_xor_q <= '0;
							status_q  <= STATUS_FULL;
							state_q   <= S_IDLE;
						end else begin
							row_q   <= rd_row;
							state_q <= S_ALLOC;
						end
					end else begin
						if (first_q && rd_row == '0) begin
							done_q    <= 1'b1;
							min_xor_q <= '0;
							status_q  <= STATUS_EMPTY;
							state_q   <= S_IDLE;
						end else if (lvl_q == '0) begin
							done_q    <= 1'b1;
							min_xor_q <= res_q;
							status_q  <= STATUS_OK;
							state_q   <= S_IDLE;
						end else if (match != '0) begin
							node_q <= match;
							lvl_q  <= lvl_m1;
						end else if (other != '0) begin
							node_q <= other;
							lvl_q  <= lvl_m1;
							res_q  <= res_q | (KEY_BITS'(1) << bit_idx);
						end else begin
							// dead end: lower bits stay clear
							done_q    <= 1'b1;
							min_xor_q <= res_q;
							status_q  <= STATUS_OK;
							state_q   <= S_IDLE;
						end
					end
				end
				S_ALLOC: begin
					// fresh nodes were cleared and never written, so their row is zero
					row_q  <= '0;
					node_q <= free_q[NODE_W-1:0];
					free_q <= free_q + FREE_W'(1);
					lvl_q  <= lvl_m1;
					if (lvl_q == KW_W'(1)) begin
						done_q    <= 1'b1;
						min_xor_q <= '0;
						status_q  <= STATUS_OK;
						state_q   <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign min_xor = min_xor_q;
	assign status  = status_q;

	`BTMX_ASSERT_NXT(a_done_pulse, clk, arst_n, done_q, !done_q)
	`BTMX_ASSERT_IMP(a_free_bound, clk, arst_n, 1'b1, free_q <= FREE_W'(NODE_COUNT))
	`BTMX_ASSERT_IMP(a_wr_states, clk, arst_n, mem_req.wr_en,
		state_q == S_CLEAR || state_q == S_ALLOC)
	`BTMX_ASSERT_IMP(a_alloc_lvl, clk, arst_n, state_q == S_ALLOC, lvl_q != '0)
	`BTMX_ASSERT_IMP(a_ins_status, clk, arst_n, done_q && op_q == OP_INSERT,
		status_q != STATUS_EMPTY)

endmodule

// ===== src/binary_trie_min_xor.sv =====
// Each item walks at most key_width levels, key_width being capped at 32. busy holds from the
// accepting edge until the done strobe, and the next item is taken only once the block is idle again.
// The walk reads one trie level per cycle from the node RAM.
// Reset: all control state clears, key_width returns to 32, and a clearing pass writes
// every one of the 4096 node rows to zero, one row a cycle, with busy held throughout.
module binary_trie_min_xor
	import btmx_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                operation,
	input  logic [KEY_BITS-1:0] key,
	input  logic                tree_select,
	input  logic                cfg_we,
	input  logic [KW_W-1:0]     cfg_wdata,
	output logic                done,
	output logic [KEY_BITS-1:0] min_xor,
	output logic [1:0]          status
);

	// Results are strobed for one cycle on done; the receiver cannot stall them.

	// number of low key bits walked; the user must write it only while idle, the block does not enforce it
	logic [KW_W-1:0] key_width_q;

	mem_req_t mem_req;
	row_t     rd_row;
	logic [ROW_W-1:0] rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_width_q <= KW_RESET;
		end else if (cfg_we) begin
			key_width_q <= cfg_wdata;
		end
	end

	// Sequencer: clears the store, then walks one level per cycle for each item,
	// and on an insert appends the missing tail of the path one node per cycle.
	btmx_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.key         (key),
		.tree_select (tree_select),
		.key_width   (key_width_q),
		.done        (done),
		.min_xor     (min_xor),
		.status      (status),
		.mem_req     (mem_req),
		.rd_row      (rd_row)
	);

	// Node store: one row of two child links per node, registered read.
	btmx_node_ram #(
		.DEPTH (NODE_COUNT),
		.WIDTH (ROW_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_data),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (rd_data)
	);

	assign rd_row = row_t'(rd_data);

endmodule
